### sv/assert_macros.svh
// Assertion macros for the top-level RTL file of the polynomial surface evaluator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### sv/pse_pkg.sv
// Package of the polynomial surface evaluator: field widths, command codes and
// elaboration-time helpers. It depends on nothing.
`default_nettype none

package pse_pkg;

    localparam int MAX_DEGREE_DEF = 4;
    localparam int COORD_BITS_DEF = 12;
    localparam int COEF_W         = 64;
    localparam int OUT_W          = 64;
    localparam int INDEX_W        = 4;
    localparam int DEGREE_W       = 3;
    localparam int FRAC_DROP      = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic int table_size(input int max_deg);
        return (max_deg + 1) * (max_deg + 2) / 2;
    endfunction

    // Table slot of the term x^t * y^l when the total degree is d.
    function automatic int coef_slot(input int t, input int l, input int d);
        return t * (d + 1) - t * (t - 1) / 2 + l;
    endfunction

    // Width that holds every Horner partial sum exactly, with room for the
    // rounding shift and the saturation check.
    function automatic int acc_width(input int max_deg, input int coord_bits);
        int w;
        w = 70 + coord_bits * max_deg;
        if (w < FRAC_DROP + OUT_W + 1)
            w = FRAC_DROP + OUT_W + 1;
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/poly_surface_eval.sv
// Bivariate polynomial surface evaluator, coefficient table, Horner pipeline.
// An evaluate transaction passes the input register, one Horner stage per step and the output register.
// Throughput: one transaction per cycle while the output is not stalled; every Horner step has its own stage.
// A coefficient write updates the table and produces no result.
// Reset (rst_n, asynchronous, active low) clears the degree, table and valids.
`default_nettype none
`include "assert_macros.svh"

module poly_surface_eval #(
    parameter int MAX_DEGREE = pse_pkg::MAX_DEGREE_DEF,
    parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pse_pkg::DEGREE_W-1:0]      cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // coef_index, coef_value, x_coord, y_coord, zero fill
    input  wire logic [((pse_pkg::INDEX_W + pse_pkg::COEF_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0]
                                                   s_tdata,
    // cmd
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // surface_value
    output logic [pse_pkg::OUT_W-1:0]              m_tdata,
    // overflow
    output logic                                   m_tuser
);

    localparam int ACC_W   = pse_pkg::acc_width(MAX_DEGREE, COORD_BITS);
    localparam int TSIZE   = pse_pkg::table_size(MAX_DEGREE);
    localparam int NSTAGE  = 2 * MAX_DEGREE;
    localparam int VAL_LO  = pse_pkg::INDEX_W;
    localparam int X_LO    = VAL_LO + pse_pkg::COEF_W;
    localparam int Y_LO    = X_LO + COORD_BITS;

    typedef logic [MAX_DEGREE:0][ACC_W-1:0] acc_vec_t;
    typedef logic [MAX_DEGREE:0][MAX_DEGREE:0][pse_pkg::COEF_W-1:0] coef_mat_t;

    logic [pse_pkg::DEGREE_W-1:0]  degree_reg;
    logic [pse_pkg::DEGREE_W-1:0]  degree_eff;
    logic [pse_pkg::COEF_W-1:0]    table_reg [TSIZE];

    logic [pse_pkg::INDEX_W-1:0]   in_index;
    logic [pse_pkg::COEF_W-1:0]    in_value;
    logic [COORD_BITS-1:0]         in_x;
    logic [COORD_BITS-1:0]         in_y;
    logic                          eval_accept;
    logic                          write_accept;
    coef_mat_t                     coef_sel;
    acc_vec_t                      acc_init;

    logic                          stg_valid [NSTAGE+1];
    logic                          stg_ready [NSTAGE+1];
    acc_vec_t                      stg_acc   [NSTAGE+1];
    coef_mat_t                     stg_coef  [NSTAGE+1];
    logic [COORD_BITS-1:0]         stg_x     [NSTAGE+1];
    logic [COORD_BITS-1:0]         stg_y     [NSTAGE+1];

    logic                          s0_valid_reg;
    acc_vec_t                      s0_acc_reg;
    coef_mat_t                     s0_coef_reg;
    logic [COORD_BITS-1:0]         s0_x_reg;
    logic [COORD_BITS-1:0]         s0_y_reg;

    assign in_index     = s_tdata[VAL_LO-1:0];
    assign in_value     = s_tdata[X_LO-1:VAL_LO];
    assign in_x         = s_tdata[Y_LO-1:X_LO];
    assign in_y         = s_tdata[Y_LO+COORD_BITS-1:Y_LO];

    assign s_tready     = !s0_valid_reg || stg_ready[0];
    assign eval_accept  = s_tvalid && s_tready && (s_tuser == pse_pkg::CMD_EVAL);
    assign write_accept = s_tvalid && s_tready && (s_tuser == pse_pkg::CMD_WRITE);

    assign degree_eff = (degree_reg > pse_pkg::DEGREE_W'(MAX_DEGREE))
                      ? pse_pkg::DEGREE_W'(MAX_DEGREE) : degree_reg;

    // Each Horner lane (x power t, y power l) takes its slot for the degree in use.
    always_comb
    begin
        for (int t = 0; t <= MAX_DEGREE; t++)
        begin
            for (int l = 0; l <= MAX_DEGREE; l++)
            begin
                coef_sel[t][l] = '0;
                for (int d = 0; d <= MAX_DEGREE; d++)
                begin
                    if ((degree_eff == pse_pkg::DEGREE_W'(d)) && (t + l <= d))
                        coef_sel[t][l] = table_reg[pse_pkg::coef_slot(t, l, d)];
                end
            end
            acc_init[t] = ACC_W'($signed(coef_sel[t][MAX_DEGREE]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg   <= '0;
            s0_valid_reg <= 1'b0;
            for (int i = 0; i < TSIZE; i++)
                table_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                degree_reg <= cfg_data;
            if (s_tready)
                s0_valid_reg <= eval_accept;
            for (int i = 0; i < TSIZE; i++)
            begin
                if (write_accept && (int'(in_index) == i))
                    table_reg[i] <= in_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_accept)
        begin
            s0_acc_reg  <= acc_init;
            s0_coef_reg <= coef_sel;
            s0_x_reg    <= in_x;
            s0_y_reg    <= in_y;
        end
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_acc[0]   = s0_acc_reg;
    assign stg_coef[0]  = s0_coef_reg;
    assign stg_x[0]     = s0_x_reg;
    assign stg_y[0]     = s0_y_reg;

    generate
        for (genvar s = 0; s < NSTAGE; s++)
        begin : g_stage
            pse_horner_stage #(
                .MAX_DEGREE (MAX_DEGREE),
                .COORD_BITS (COORD_BITS),
                .ACC_W      (ACC_W),
                .STEP       (s)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stg_valid[s]),
                .in_ready  (stg_ready[s]),
                .in_acc    (stg_acc[s]),
                .in_coef   (stg_coef[s]),
                .in_x      (stg_x[s]),
                .in_y      (stg_y[s]),
                .out_valid (stg_valid[s+1]),
                .out_ready (stg_ready[s+1]),
                .out_acc   (stg_acc[s+1]),
                .out_coef  (stg_coef[s+1]),
                .out_x     (stg_x[s+1]),
                .out_y     (stg_y[s+1])
            );
        end
    endgenerate

    pse_round_sat #(
        .ACC_W (ACC_W)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stg_valid[NSTAGE]),
        .in_ready     (stg_ready[NSTAGE]),
        .in_acc       (stg_acc[NSTAGE][MAX_DEGREE]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_overflow (m_tuser)
    );

    `ASSERT_IMPLIES(a_sat_value, m_tvalid && m_tuser,
        (m_tdata == pse_pkg::SAT_POS) || (m_tdata == pse_pkg::SAT_NEG))
    `ASSERT_IMPLIES(a_stall_from_output, !s_tready, m_tvalid && !m_tready)
    `ASSERT_ALWAYS(a_degree_clamped, degree_eff <= pse_pkg::DEGREE_W'(MAX_DEGREE),
        "effective degree above maximum")

endmodule

`default_nettype wire

### sv/pse_horner_stage.sv
// One registered Horner step of the surface evaluator: a y step on every lane,
// or an x step into the top lane. Depends on pse_pkg.
`default_nettype none

module pse_horner_stage #(
    parameter int MAX_DEGREE = pse_pkg::MAX_DEGREE_DEF,
    parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF,
    parameter int ACC_W      = pse_pkg::acc_width(MAX_DEGREE, COORD_BITS),
    parameter int STEP       = 0
) (
    input  wire logic                                                clk,
    input  wire logic                                                rst_n,
    input  wire logic                                                in_valid,
    output logic                                                     in_ready,
    input  wire logic [MAX_DEGREE:0][ACC_W-1:0]                      in_acc,
    input  wire logic [MAX_DEGREE:0][MAX_DEGREE:0][pse_pkg::COEF_W-1:0] in_coef,
    input  wire logic [COORD_BITS-1:0]                               in_x,
    input  wire logic [COORD_BITS-1:0]                               in_y,
    output logic                                                     out_valid,
    input  wire logic                                                out_ready,
    output logic [MAX_DEGREE:0][ACC_W-1:0]                           out_acc,
    output logic [MAX_DEGREE:0][MAX_DEGREE:0][pse_pkg::COEF_W-1:0]  out_coef,
    output logic [COORD_BITS-1:0]                                    out_x,
    output logic [COORD_BITS-1:0]                                    out_y
);

    logic                                               valid_reg;
    logic [MAX_DEGREE:0][ACC_W-1:0]                     acc_reg;
    logic [MAX_DEGREE:0][ACC_W-1:0]                     acc_next;
    logic [MAX_DEGREE:0][MAX_DEGREE:0][pse_pkg::COEF_W-1:0] coef_reg;
    logic [COORD_BITS-1:0]                              x_reg;
    logic [COORD_BITS-1:0]                              y_reg;
    logic signed [MAX_DEGREE:0][ACC_W+COORD_BITS:0]     prod;

    assign in_ready = !valid_reg || out_ready;

    generate
        if (STEP < MAX_DEGREE) begin : g_y_step
            localparam int LANE_L = MAX_DEGREE - (STEP + 1);
            // Every lane t folds in its coefficient of y^LANE_L.
            always_comb
            begin
                acc_next = in_acc;
                for (int t = 0; t <= MAX_DEGREE; t++)
                begin
                    prod[t] = $signed(in_acc[t]) * $signed({1'b0, in_y});
                    acc_next[t] = prod[t][ACC_W-1:0]
                        + ACC_W'($signed(in_coef[t][LANE_L]));
                end
            end
        end else begin : g_x_step
            localparam int LANE_T = MAX_DEGREE - (STEP - MAX_DEGREE + 1);
            // The top lane collects the sum over x powers.
            always_comb
            begin
                acc_next = in_acc;
                for (int t = 0; t <= MAX_DEGREE; t++)
                    prod[t] = '0;
                prod[MAX_DEGREE] = $signed(in_acc[MAX_DEGREE]) * $signed({1'b0, in_x});
                acc_next[MAX_DEGREE] = prod[MAX_DEGREE][ACC_W-1:0] + in_acc[LANE_T];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            acc_reg  <= acc_next;
            coef_reg <= in_coef;
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_coef  = coef_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

`default_nettype wire

### sv/pse_round_sat.sv
// Output stage of the surface evaluator: rounds the exact sum to Q40.24,
// saturates to 64 bits and holds the result. Depends on pse_pkg.
`default_nettype none

module pse_round_sat #(
    parameter int ACC_W = pse_pkg::acc_width(pse_pkg::MAX_DEGREE_DEF,
                                             pse_pkg::COORD_BITS_DEF)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ACC_W-1:0]          in_acc,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [pse_pkg::OUT_W-1:0]      out_value,
    output logic                           out_overflow
);

    localparam int SH_W = ACC_W - pse_pkg::FRAC_DROP;

    logic                         valid_reg;
    logic [pse_pkg::OUT_W-1:0]    value_reg;
    logic [pse_pkg::OUT_W-1:0]    value_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [ACC_W-1:0]             rounded;
    logic [SH_W-1:0]              shifted;
    logic                         fits;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rounded  = in_acc + (ACC_W'(1) << (pse_pkg::FRAC_DROP - 1));
        shifted  = rounded[ACC_W-1:pse_pkg::FRAC_DROP];
        // The value fits when all bits above the result agree with its sign.
        fits     = (&shifted[SH_W-1:pse_pkg::OUT_W-1]) || !(|shifted[SH_W-1:pse_pkg::OUT_W-1]);
        ovf_next = !fits;
        if (fits)
            value_next = shifted[pse_pkg::OUT_W-1:0];
        else if (shifted[SH_W-1])
            value_next = pse_pkg::SAT_NEG;
        else
            value_next = pse_pkg::SAT_POS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_value    = value_reg;
    assign out_overflow = ovf_reg;

endmodule

`default_nettype wire
